/* rtl/drdt_pkg.sv */
// ---------------------------------------------------------------------------
// drdt_pkg
// Shared types, codes and defaults for the default router discovery table.
// ---------------------------------------------------------------------------
package drdt_pkg;

   localparam int DEF_TABLE_ENTRIES    = 16;
   localparam int DEF_TICKS_PER_SECOND = 1000;

   localparam logic [1:0] OP_ADVERT = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_IFDOWN = 2'd2;
   localparam logic [1:0] OP_PICK   = 2'd3;

   localparam logic [1:0] SRC_GDP  = 2'd0;
   localparam logic [1:0] SRC_IRDP = 2'd3;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_DISABLED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_MISMATCH = 2'd3;

   localparam logic [1:0] REG_SOURCE_ENABLE = 2'd0;
   localparam logic [1:0] REG_MIN_INTERVAL  = 2'd1;
   localparam logic [1:0] REG_SWEEP_PERIOD  = 2'd2;
   localparam logic [1:0] REG_REPICK_PERIOD = 2'd3;

   localparam logic [1:0] AV_ZERO = 2'd0;
   localparam logic [1:0] AV_GW   = 2'd1;
   localparam logic [1:0] AV_ADDR = 2'd2;

   localparam logic [31:0] BLACK_HOLE       = 32'h8000_0000;
   localparam logic [31:0] RST_MIN_INTERVAL = 32'd1000;
   localparam logic [31:0] RST_SWEEP_PERIOD = 32'd10000;
   localparam logic [31:0] RST_REPICK_PER   = 32'd300000;

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_LOOKUP, S_UPDATE, S_SWEEP, S_PICK, S_DONE
   } drdt_state_type;

   typedef struct packed {
      logic       load;
      logic       scan_step;
      logic       create;
      logic       update;
      logic       sweep_init;
      logic       drop;
      logic       repick_init;
      logic       pick_init;
      logic [1:0] avoid_sel;
      logic       dst_gw;
      logic       pick_step;
      logic       pick_commit;
      logic       set_status;
      logic [1:0] status;
      logic       rsp_load;
   } drdt_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       src_off;
      logic       scan_end;
      logic       hit;
      logic       full;
      logic       tick_due;
      logic       drop_hit;
      logic       gw_hit;
      logic       pick_end;
      logic       repick_due;
      logic       rsp_free;
   } drdt_sts_type;

endpackage

/* rtl/drdt_ctrl.sv */
// ---------------------------------------------------------------------------
// drdt_ctrl
// Sequencer: lookup, update, sweeps and pick passes over the table.
// ---------------------------------------------------------------------------
module drdt_ctrl
   import drdt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  drdt_sts_type sts,
   output drdt_cmd_type cmd
);

   drdt_state_type state_ff, state_in;
   logic           ret_sweep_ff, ret_sweep_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_sweep_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_sweep_ff <= ret_sweep_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_sweep_in = ret_sweep_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_START;
         S_START: begin
            case (sts.op)
               OP_ADVERT: state_in = sts.src_off ? S_DONE : S_LOOKUP;
               OP_TICK:   state_in = sts.tick_due ? S_SWEEP : S_DONE;
               OP_IFDOWN: state_in = S_SWEEP;
               default: begin
                  state_in     = S_PICK;
                  ret_sweep_in = 1'b0;
               end
            endcase
         end
         S_LOOKUP: begin
            if (sts.scan_end) state_in = sts.full ? S_DONE : S_UPDATE;
            else if (sts.hit) state_in = S_UPDATE;
         end
         S_UPDATE: state_in = S_DONE;
         S_SWEEP: begin
            if (sts.scan_end) begin
               if (sts.op == OP_TICK && sts.repick_due) begin
                  state_in     = S_PICK;
                  ret_sweep_in = 1'b0;
               end else begin
                  state_in = S_DONE;
               end
            end else if (sts.drop_hit && sts.gw_hit) begin
               state_in     = S_PICK;
               ret_sweep_in = 1'b1;
            end
         end
         S_PICK: if (sts.pick_end) state_in = ret_sweep_ff ? S_SWEEP : S_DONE;
         S_DONE: if (sts.rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: cmd.load = req_valid;
         S_START: begin
            case (sts.op)
               OP_ADVERT: begin
                  cmd.set_status = sts.src_off;
                  cmd.status     = ST_DISABLED;
               end
               OP_TICK: cmd.sweep_init = sts.tick_due;
               OP_IFDOWN: cmd.scan_step = 1'b0;
               default: begin
                  cmd.pick_init = 1'b1;
                  cmd.avoid_sel = AV_ADDR;
               end
            endcase
         end
         S_LOOKUP: begin
            if (sts.scan_end) begin
               cmd.set_status = sts.full;
               cmd.status     = ST_FULL;
               cmd.create     = !sts.full;
            end else if (!sts.hit) begin
               cmd.scan_step = 1'b1;
            end
         end
         S_UPDATE: cmd.update = 1'b1;
         S_SWEEP: begin
            if (sts.scan_end) begin
               if (sts.op == OP_TICK && sts.repick_due) begin
                  cmd.repick_init = 1'b1;
                  cmd.pick_init   = 1'b1;
                  cmd.avoid_sel   = AV_ZERO;
                  cmd.dst_gw      = 1'b1;
               end
            end else if (sts.drop_hit) begin
               cmd.drop = 1'b1;
               if (sts.gw_hit) begin
                  cmd.pick_init = 1'b1;
                  cmd.avoid_sel = AV_GW;
                  cmd.dst_gw    = 1'b1;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_PICK: begin
            if (sts.pick_end) cmd.pick_commit = 1'b1;
            else cmd.pick_step = 1'b1;
         end
         S_DONE: cmd.rsp_load = sts.rsp_free;
         default: cmd = '0;
      endcase
   end

`ifndef SYNTH
   a_update_after_lookup: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPDATE |-> $past(state_ff) == S_LOOKUP)
      else $error("update without lookup");
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_START)
      else $error("load did not start");
   a_pick_return: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PICK && sts.pick_end && ret_sweep_ff) |=> state_ff == S_SWEEP)
      else $error("pick did not resume sweep");
`endif

endmodule

/* rtl/drdt_dp.sv */
// ---------------------------------------------------------------------------
// drdt_dp
// Datapath: router table, configuration, item latch, pick unit, result beat.
// ---------------------------------------------------------------------------
module drdt_dp
   import drdt_pkg::*;
#(
   parameter int TABLE_ENTRIES    = DEF_TABLE_ENTRIES,
   parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
   input  logic               clock,
   input  logic               reset,
   input  drdt_cmd_type       cmd,
   output drdt_sts_type       sts,
   input  logic [1:0]         req_op,
   input  logic [31:0]        req_now_ms,
   input  logic [31:0]        req_router_address,
   input  logic [1:0]         req_source,
   input  logic signed [31:0] req_priority_req,
   input  logic [15:0]        req_holdtime_s,
   input  logic [7:0]         req_interface_id,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_default_gateway,
   output logic               rsp_gateway_changed,
   output logic [31:0]        rsp_picked_address,
   output logic [1:0]         rsp_status
);

   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int TW = $clog2(TICKS_PER_SECOND + 1);
   localparam int SW = 16 + TW;

   function automatic logic reached(input logic [31:0] now, input logic [31:0] dl);
      logic [31:0] d;
      d = now - dl;
      return !d[31];
   endfunction

   logic [3:0]  en_ff;
   logic [31:0] min_ff, sweep_per_ff, repick_per_ff;
   logic [CW-1:0] used_ff, idx_ff, pidx_ff;
   logic [IW-1:0] ix, px;

   logic [31:0]        addr_q  [TABLE_ENTRIES];
   logic [1:0]         src_q   [TABLE_ENTRIES];
   logic signed [31:0] prio_q  [TABLE_ENTRIES];
   logic [31:0]        int_q   [TABLE_ENTRIES];
   logic [31:0]        lu_q    [TABLE_ENTRIES];
   logic               lr_q    [TABLE_ENTRIES];
   logic [31:0]        exp_q   [TABLE_ENTRIES];
   logic [7:0]         ifc_q   [TABLE_ENTRIES];

   logic [1:0]         op_ff, rsrc_ff;
   logic [31:0]        now_ff, raddr_ff;
   logic signed [31:0] rprio_ff;
   logic [SW-1:0]      span_ff;
   logic [7:0]         rifc_ff;

   logic [31:0] gw_ff, gw_before_ff, sweep_dl_ff, repick_dl_ff, picked_ff;
   logic [1:0]  status_ff;

   logic               have_best_ff, have_cur_ff, dst_gw_ff;
   logic [1:0]         best_src_ff;
   logic signed [31:0] best_prio_ff;
   logic [31:0]        best_addr_ff, cur_addr_ff, avoid_ff, avoid_in;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_gw_ff, rsp_pick_ff;
   logic               rsp_chg_ff;
   logic [1:0]         rsp_st_ff;

   // update arithmetic
   logic [63:0] span64;
   logic [31:0] el, iv, int_in, exp_in, sm;
   logic [34:0] acc;
   logic        ok_el, take_in;
   logic [1:0]  upd_st;

   // pick element
   logic [31:0]        e_addr, pick_res;
   logic [1:0]         e_src;
   logic signed [31:0] e_prio;
   logic               e_av, e_take;

   assign ix = idx_ff[IW-1:0];
   assign px = pidx_ff[IW-1:0];

   always_comb begin
      span64 = 64'(span_ff);
      el     = now_ff - lu_q[ix];
      iv     = int_q[ix];
      ok_el  = !el[31] && (el > min_ff);
      acc    = 35'({iv, 3'b000}) - 35'(iv) + 35'(el);
      sm     = acc[34:3];
      int_in = iv;
      exp_in = exp_q[ix];
      take_in = 1'b1;
      upd_st  = ST_DONE;
      if (iv == 32'd0) begin
         if (lr_q[ix] && ok_el) begin
            int_in = el;
            exp_in = now_ff + {el[30:0], 1'b0} + {1'b0, el[31:1]};
         end
      end else if (src_q[ix] != rsrc_ff && rsrc_ff != SRC_IRDP) begin
         take_in = 1'b0;
         upd_st  = ST_MISMATCH;
      end else if (ok_el) begin
         int_in = sm;
         exp_in = now_ff + {sm[30:0], 1'b0} + {1'b0, sm[31:1]};
      end
      if (rsrc_ff == SRC_GDP || rsrc_ff == SRC_IRDP) begin
         exp_in = now_ff + span64[31:0];
         if (int_in == 32'd0) int_in = span64[32:1];
      end
   end

   always_comb begin
      e_addr = addr_q[px];
      e_src  = src_q[px];
      e_prio = prio_q[px];
      e_av   = (e_addr == avoid_ff);
      e_take = 1'b0;
      if (!e_av) begin
         if (en_ff[SRC_IRDP]) begin
            if (have_best_ff && best_src_ff == SRC_IRDP && e_src != SRC_IRDP)
               e_take = 1'b0;
            else if (e_prio == $signed(BLACK_HOLE))
               e_take = 1'b0;
            else if (!have_best_ff)
               e_take = 1'b1;
            else if (e_src == SRC_IRDP)
               e_take = (e_prio < best_prio_ff) || (best_src_ff != SRC_IRDP);
            else
               e_take = (e_prio > best_prio_ff);
         end else begin
            e_take = !have_best_ff || (e_prio > best_prio_ff);
         end
      end
      pick_res = have_best_ff ? best_addr_ff : (have_cur_ff ? cur_addr_ff : 32'd0);
      case (cmd.avoid_sel)
         AV_GW:   avoid_in = gw_ff;
         AV_ADDR: avoid_in = raddr_ff;
         default: avoid_in = 32'd0;
      endcase
   end

   always_comb begin
      sts            = '0;
      sts.op         = op_ff;
      sts.src_off    = !en_ff[rsrc_ff];
      sts.scan_end   = (idx_ff >= used_ff);
      sts.hit        = (addr_q[ix] == raddr_ff);
      sts.full       = (used_ff == CW'(TABLE_ENTRIES));
      sts.tick_due   = reached(now_ff, sweep_dl_ff);
      sts.drop_hit   = (op_ff == OP_TICK)
                     ? (int_q[ix] != 32'd0 && reached(now_ff, exp_q[ix]))
                     : (ifc_q[ix] == rifc_ff);
      sts.gw_hit     = (addr_q[ix] == gw_ff);
      sts.pick_end   = (pidx_ff >= used_ff);
      sts.repick_due = reached(now_ff, repick_dl_ff) || (gw_ff == 32'd0);
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff         <= 4'd0;
         min_ff        <= RST_MIN_INTERVAL;
         sweep_per_ff  <= RST_SWEEP_PERIOD;
         repick_per_ff <= RST_REPICK_PER;
         used_ff       <= '0;
         idx_ff        <= '0;
         pidx_ff       <= '0;
         gw_ff         <= 32'd0;
         sweep_dl_ff   <= 32'(30 * TICKS_PER_SECOND);
         repick_dl_ff  <= 32'(30 * TICKS_PER_SECOND);
         rsp_valid_ff  <= 1'b0;
         have_best_ff  <= 1'b0;
         have_cur_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_SOURCE_ENABLE: en_ff         <= csr_data[3:0];
               REG_MIN_INTERVAL:  min_ff        <= csr_data;
               REG_SWEEP_PERIOD:  sweep_per_ff  <= csr_data;
               REG_REPICK_PERIOD: repick_per_ff <= csr_data;
               default:           en_ff         <= en_ff;
            endcase
         end
         if (cmd.load) idx_ff <= '0;
         if (cmd.sweep_init) begin
            idx_ff      <= '0;
            sweep_dl_ff <= now_ff + sweep_per_ff;
         end
         if (cmd.scan_step) idx_ff <= idx_ff + CW'(1);
         if (cmd.create) used_ff <= used_ff + CW'(1);
         if (cmd.drop) used_ff <= used_ff - CW'(1);
         if (cmd.repick_init) repick_dl_ff <= now_ff + repick_per_ff;
         if (cmd.pick_init) begin
            pidx_ff      <= '0;
            have_best_ff <= 1'b0;
            have_cur_ff  <= 1'b0;
         end
         if (cmd.pick_step) begin
            pidx_ff <= pidx_ff + CW'(1);
            if (e_av) have_cur_ff <= 1'b1;
            if (e_take) have_best_ff <= 1'b1;
         end
         if (cmd.pick_commit && dst_gw_ff) gw_ff <= pick_res;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_op;
         now_ff       <= req_now_ms;
         raddr_ff     <= req_router_address;
         rsrc_ff      <= req_source;
         rprio_ff     <= req_priority_req;
         span_ff      <= SW'(req_holdtime_s) * SW'(TICKS_PER_SECOND);
         rifc_ff      <= req_interface_id;
         gw_before_ff <= gw_ff;
         picked_ff    <= 32'd0;
         status_ff    <= ST_DONE;
      end
      if (cmd.set_status) status_ff <= cmd.status;
      if (cmd.update) status_ff <= upd_st;
      if (cmd.pick_init) begin
         avoid_ff  <= avoid_in;
         dst_gw_ff <= cmd.dst_gw;
      end
      if (cmd.pick_step) begin
         if (e_av) cur_addr_ff <= e_addr;
         if (e_take) begin
            best_addr_ff <= e_addr;
            best_src_ff  <= e_src;
            best_prio_ff <= e_prio;
         end
      end
      if (cmd.pick_commit && !dst_gw_ff) picked_ff <= pick_res;
      if (cmd.create) begin
         addr_q[ix] <= raddr_ff;
         int_q[ix]  <= 32'd0;
         lr_q[ix]   <= 1'b0;
      end
      if (cmd.update) begin
         int_q[ix] <= int_in;
         exp_q[ix] <= exp_in;
         if (take_in) begin
            lu_q[ix]   <= now_ff;
            lr_q[ix]   <= 1'b1;
            prio_q[ix] <= rprio_ff;
            src_q[ix]  <= rsrc_ff;
            ifc_q[ix]  <= rifc_ff;
         end
      end
      if (cmd.drop) begin
         for (int j = 0; j < TABLE_ENTRIES - 1; j++) begin
            if (CW'(j) >= idx_ff) begin
               addr_q[j] <= addr_q[j + 1];
               src_q[j]  <= src_q[j + 1];
               prio_q[j] <= prio_q[j + 1];
               int_q[j]  <= int_q[j + 1];
               lu_q[j]   <= lu_q[j + 1];
               lr_q[j]   <= lr_q[j + 1];
               exp_q[j]  <= exp_q[j + 1];
               ifc_q[j]  <= ifc_q[j + 1];
            end
         end
      end
      if (cmd.rsp_load) begin
         rsp_gw_ff   <= gw_ff;
         rsp_chg_ff  <= (gw_ff != gw_before_ff);
         rsp_pick_ff <= picked_ff;
         rsp_st_ff   <= status_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_default_gateway = rsp_gw_ff;
   assign rsp_gateway_changed = rsp_chg_ff;
   assign rsp_picked_address  = rsp_pick_ff;
   assign rsp_status          = rsp_st_ff;

`ifndef SYNTH
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(TABLE_ENTRIES))
      else $error("table count overflow");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= used_ff)
      else $error("scan index beyond table");
   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> rsp_chg_ff == (rsp_gw_ff != gw_before_ff))
      else $error("gateway change flag wrong");
`endif

endmodule

/* rtl/default_router_discovery_table_top.sv */
// ---------------------------------------------------------------------------
// default_router_discovery_table_top
// Learns candidate routers from adverts and keeps the default gateway.
// One item at a time: an advert runs a linear lookup over the table, then
// creates the entry if it is missing and the table is not full, and updates
// it; a pick request runs one pick pass; a sweep (tick or interface down)
// walks the table and runs one pick pass for every removed gateway entry,
// and a due tick also runs the periodic re-pick. A tick that is not yet due
// and a disabled advert go straight to the result. A waiting result beat
// that is held off holds the sequencer in its done state until it can be
// loaded.
// One result beat per item; the result register lets the next item in
// while a beat waits.
// ---------------------------------------------------------------------------
module default_router_discovery_table_top
   import drdt_pkg::*;
#(
   parameter int TABLE_ENTRIES    = DEF_TABLE_ENTRIES,
   parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [31:0]        req_now_ms,
   input  logic [31:0]        req_router_address,
   input  logic [1:0]         req_source,
   input  logic signed [31:0] req_priority_req,
   input  logic [15:0]        req_holdtime_s,
   input  logic [7:0]         req_interface_id,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_default_gateway,
   output logic               rsp_gateway_changed,
   output logic [31:0]        rsp_picked_address,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   drdt_cmd_type cmd;
   drdt_sts_type sts;

   assign csr_ready = 1'b1;

   drdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   drdt_dp #(
      .TABLE_ENTRIES    (TABLE_ENTRIES),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_op              (req_op),
      .req_now_ms          (req_now_ms),
      .req_router_address  (req_router_address),
      .req_source          (req_source),
      .req_priority_req    (req_priority_req),
      .req_holdtime_s      (req_holdtime_s),
      .req_interface_id    (req_interface_id),
      .csr_valid           (csr_valid & csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_default_gateway (rsp_default_gateway),
      .rsp_gateway_changed (rsp_gateway_changed),
      .rsp_picked_address  (rsp_picked_address),
      .rsp_status          (rsp_status)
   );

endmodule
